// ===== hw/rtl/mpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mpq_pkg
// Types, codes and the ranking function shared by the priority queue files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mpq_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_PEEK   = 2'd1,
        OP_POP    = 2'd2,
        OP_SILENT = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_VALID = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic [15:0] score;
        logic [31:0] roll;
        logic [15:0] tag;
    } rec_t;

    // Command broadcast to every cell; both low means hold.
    typedef struct packed {
        logic ins;
        logic pop;
    } cell_ctrl_t;

    // True when a ranks strictly above b.
    function automatic logic ranks_above(input rec_t a, input rec_t b);
        logic res;
        if (a.score != b.score)
        begin
            res = (a.score > b.score);
        end
        else
        begin
            res = (a.roll < b.roll);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mpq_if.sv =====
// ----------------------------------------------------------------------------
// mpq interfaces
// Request and response channels of the priority queue, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mpq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [15:0] score;
    logic [31:0] roll_number;
    logic [15:0] tag;

    modport source (output valid, output opcode, output score, output roll_number,
                    output tag, input ready);
    modport sink   (input valid, input opcode, input score, input roll_number,
                    input tag, output ready);
endinterface

interface mpq_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] top_score;
    logic [31:0] top_roll;
    logic [15:0] top_tag;

    modport source (output valid, output status, output top_score, output top_roll,
                    output top_tag, input ready);
    modport sink   (input valid, input status, input top_score, input top_roll,
                    input top_tag, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/max_priority_queue_tiebreak_core.sv =====
// ----------------------------------------------------------------------------
// max_priority_queue_tiebreak_core
// Bounded max priority queue kept as a sorted chain of cells, head first.
// ----------------------------------------------------------------------------
// Sequence: a request is taken in S_IDLE, runs in S_EXEC, and its response, if any, is registered
// when the chain commits; the next request is taken only after that. The chain updates in one step.
// A response waiting for its sink holds the chain update of any request that needs a response.
// Reset: occupancy and handshake state clear at once; cell contents undefined.
`timescale 1ns / 1ps
`default_nettype none

module max_priority_queue_tiebreak_core
    import mpq_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  wire       clk,
    input  wire       rst_n,
    mpq_req_if.sink   cmd,
    mpq_rsp_if.source rsp
);

    localparam int CW = $clog2(DEPTH + 1);

    state_t         state_reg;
    state_t         state_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    op_t            op_reg;
    rec_t           new_reg;

    logic           out_valid_reg;
    logic           out_valid_next;
    status_t        out_status_reg;
    rec_t           out_rec_reg;

    rec_t           cell_rec   [DEPTH];
    rec_t           cell_rec_nx[DEPTH];
    logic [DEPTH-1:0] cell_above;
    logic [DEPTH-1:0] occ;
    cell_ctrl_t     ctrl;

    logic           is_full;
    logic           is_empty;
    logic           is_insert;
    logic           need_rsp;
    logic           commit;
    logic           load;

    assign is_full   = (count_reg == CW'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign is_insert = (op_reg == OP_INSERT) || (op_reg == OP_SILENT);

    always_comb
    begin
        case (op_reg)
            OP_INSERT, OP_PEEK, OP_POP: need_rsp = 1'b1;
            OP_SILENT:                  need_rsp = is_full;
            default:                    need_rsp = 1'b1;
        endcase
    end

    // Chain moves only when the response slot can take the result, or when no response is needed.
    assign commit = (state_reg == S_EXEC) && (!need_rsp || !out_valid_reg || rsp.ready);
    assign load   = commit && need_rsp;

    always_comb
    begin
        ctrl.ins   = commit && is_insert && !is_full;
        ctrl.pop   = commit && (op_reg == OP_POP) && !is_empty;
        count_next = count_reg;
        if (ctrl.ins)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign cmd.ready = (state_reg == S_IDLE);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            op_reg        <= op_t'(cmd.opcode);
            new_reg.score <= cmd.score;
            new_reg.roll  <= cmd.roll_number;
            new_reg.tag   <= cmd.tag;
        end
        if (load)
        begin
            if (count_next == '0)
            begin
                out_status_reg <= ST_EMPTY;
                out_rec_reg    <= '0;
            end
            else
            begin
                out_status_reg <= (is_insert && is_full) ? ST_FULL : ST_VALID;
                out_rec_reg    <= cell_rec_nx[0];
            end
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            localparam logic [CW-1:0] IDX = CW'(gi);
            rec_t left_rec;
            logic left_above;
            rec_t right_rec;

            assign occ[gi] = (IDX < count_reg);

            if (gi == 0)
            begin : g_head
                assign left_rec   = new_reg;
                assign left_above = 1'b0;
            end
            else
            begin : g_body
                assign left_rec   = cell_rec[gi-1];
                assign left_above = cell_above[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                assign right_rec = cell_rec[gi];
            end
            else
            begin : g_inner
                assign right_rec = cell_rec[gi+1];
            end

            mpq_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .new_rec    (new_reg),
                .occupied   (occ[gi]),
                .left_rec   (left_rec),
                .left_above (left_above),
                .right_rec  (right_rec),
                .rec        (cell_rec[gi]),
                .above      (cell_above[gi]),
                .rec_nx     (cell_rec_nx[gi])
            );
        end
    endgenerate

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.top_score = out_rec_reg.score;
    assign rsp.top_roll  = out_rec_reg.roll;
    assign rsp.top_tag   = out_rec_reg.tag;

endmodule

`default_nettype wire

// ===== hw/rtl/mpq_cell.sv =====
// ----------------------------------------------------------------------------
// mpq_cell
// One slot of the sorted chain: holds a record, takes the new one, its left
// neighbour's record or its right neighbour's record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mpq_cell
    import mpq_pkg::*;
(
    input  wire        clk,
    input  cell_ctrl_t ctrl,
    input  rec_t       new_rec,
    input  wire        occupied,
    input  rec_t       left_rec,
    input  wire        left_above,
    input  rec_t       right_rec,
    output rec_t       rec,
    output logic       above,
    output rec_t       rec_nx
);

    rec_t rec_reg;
    rec_t rec_next;

    // Empty slots always sit below the new record.
    assign above = !occupied || ranks_above(new_rec, rec_reg);

    always_comb
    begin
        rec_next = rec_reg;
        if (ctrl.ins)
        begin
            if (above && !left_above)
            begin
                rec_next = new_rec;
            end
            else if (above)
            begin
                rec_next = left_rec;
            end
        end
        else if (ctrl.pop)
        begin
            rec_next = right_rec;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign rec    = rec_reg;
    assign rec_nx = rec_next;

endmodule

`default_nettype wire

// ===== hw/rtl/mpq_checker.sv =====
// ----------------------------------------------------------------------------
// mpq_checker
// Port-level checks on the priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mpq_checker
    import mpq_pkg::*;
(
    input wire        clk,
    input wire        rst_n,
    input wire        cmd_valid,
    input wire        cmd_ready,
    input wire        rsp_valid,
    input wire        rsp_ready,
    input wire [1:0]  rsp_status,
    input wire [15:0] rsp_score,
    input wire [31:0] rsp_roll,
    input wire [15:0] rsp_tag
);

    // At most one request in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("request taken while previous one still executing");

    // A fresh response must trace back to a request that was taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(cmd_valid && cmd_ready, 2))
        else $error("response without a preceding request");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_EMPTY) |->
            (rsp_score == '0) && (rsp_roll == '0) && (rsp_tag == '0))
        else $error("empty response carries a record");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_score) && $stable(rsp_roll) && $stable(rsp_tag))
        else $error("stalled response changed");

endmodule

bind max_priority_queue_tiebreak_core mpq_checker u_mpq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_score  (rsp.top_score),
    .rsp_roll   (rsp.top_roll),
    .rsp_tag    (rsp.top_tag)
);

`default_nettype wire
